FILE: rtl/core/named_byte_record_store_defines.svh
// Assertion macros shared by the checker.
`ifndef NAMED_BYTE_RECORD_STORE_DEFINES_SVH
`define NAMED_BYTE_RECORD_STORE_DEFINES_SVH

// An implication checked on every clock edge outside reset.
`define NBRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequence is checked after the condition holds, not with it.
`define NBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nbrs_pkg.sv
`default_nettype none
package nbrs_pkg;
    localparam logic [7:0] END_MARK = 8'hFF;
    localparam logic [2:0] ST_FOUND = 3'd0;
    localparam logic [2:0] ST_ADDED = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    // Command handed from the front part to the back part.
    typedef struct packed {
        logic       mode;
        logic       too_long;
        logic [7:0] value;
        logic [7:0] count;
    } nbrs_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/nbrs_ram.sv
`default_nettype none
module nbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/nbrs_front.sv
`default_nettype none
// Collects name bytes into the name buffer and issues one command per name.
module nbrs_front #(
    parameter int MAX_NAME = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [7:0]                  name_byte,
    input  wire logic                        name_end,
    input  wire logic [7:0]                  value,
    input  wire logic                        back_busy,
    output logic                             nb_we,
    output logic [$clog2(MAX_NAME+1)-1:0]    nb_waddr,
    output logic [7:0]                       nb_wdata,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output nbrs_pkg::nbrs_cmd_t              cmd
);
    localparam int CW = $clog2(MAX_NAME + 1);

    logic [CW-1:0]       count_reg, count_next;
    logic                long_reg, long_next;
    logic                cmd_valid_reg, cmd_valid_next;
    nbrs_pkg::nbrs_cmd_t cmd_reg, cmd_next;
    logic                take, has_room;

    // The back part reads the buffer during its walk and its append, so the
    // front holds off new names until the queued command has been taken and
    // the back part is done with the buffer.
    assign in_ready = !cmd_valid_reg && !back_busy;
    assign take = in_valid && in_ready;
    assign has_room = count_reg < CW'(MAX_NAME);
    assign nb_we = take && has_room;
    assign nb_waddr = count_reg;
    assign nb_wdata = name_byte;
    assign cmd_valid = cmd_valid_reg;
    assign cmd = cmd_reg;

    always_comb
    begin
        count_next = count_reg;
        long_next = long_reg;
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next = cmd_reg;
        if (take)
        begin
            if (has_room)
            begin
                count_next = count_reg + CW'(1);
            end
            if (name_end)
            begin
                cmd_valid_next = 1'b1;
                cmd_next.mode = mode;
                cmd_next.value = value;
                cmd_next.too_long = long_reg || !has_room;
                cmd_next.count = has_room ? 8'(count_reg + CW'(1)) : 8'(count_reg);
                count_next = '0;
                long_next = 1'b0;
            end
            else if (!has_room)
            begin
                long_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            long_reg <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            long_reg <= long_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end
endmodule
`default_nettype wire

FILE: rtl/core/nbrs_back.sv
`default_nettype none
// Walks the record list for one command and carries out the read or write.
module nbrs_back #(
    parameter int STORE_BYTES = 256,
    parameter int MAX_NAME = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire nbrs_pkg::nbrs_cmd_t         cmd,
    output logic                             busy,
    output logic [$clog2(MAX_NAME+1)-1:0]    nb_raddr,
    input  wire logic [7:0]                  nb_rdata,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       read_value,
    output logic [2:0]                       status
);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int NW = $clog2(MAX_NAME + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PTR    = 10'b0000000010,
        S_PTRW   = 10'b0000000100,
        S_CMP    = 10'b0000001000,
        S_CMPW   = 10'b0000010000,
        S_VAL    = 10'b0000100000,
        S_VALW   = 10'b0001000000,
        S_APP    = 10'b0010000000,
        S_APPW   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    nbrs_pkg::nbrs_cmd_t c_reg, c_next;
    logic [8:0]          addr_reg, addr_next;
    logic [7:0]          ptr_reg, ptr_next;
    logic [8:0]          idx_reg, idx_next;
    logic [7:0]          rv_reg, rv_next;
    logic [2:0]          st_reg, st_next;
    logic                init_reg, init_next;
    logic                st_we;
    logic [AW-1:0]       st_waddr, st_raddr;
    logic [7:0]          st_wdata, st_rdata;
    logic [8:0]          vaddr;

    nbrs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    assign cmd_ready = (state_reg == S_IDLE) && init_reg;
    // The name buffer is in use from the transfer of a command until the result is ready.
    assign busy = !(state_reg == S_IDLE || state_reg == S_OUT);
    assign out_valid = state_reg == S_OUT;
    assign read_value = rv_reg;
    assign status = st_reg;
    assign vaddr = addr_reg + 9'(c_reg.count) + 9'd1;

    always_comb
    begin
        state_next = state_reg;
        c_next = c_reg;
        addr_next = addr_reg;
        ptr_next = ptr_reg;
        idx_next = idx_reg;
        rv_next = rv_reg;
        st_next = st_reg;
        init_next = 1'b1;
        st_we = 1'b0;
        st_waddr = '0;
        st_wdata = nbrs_pkg::END_MARK;
        st_raddr = AW'(addr_reg);
        nb_raddr = NW'(idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                // One write after reset places the end mark at byte 0.
                if (!init_reg)
                begin
                    st_we = 1'b1;
                end
                else if (cmd_valid)
                begin
                    c_next = cmd;
                    rv_next = 8'd0;
                    addr_next = '0;
                    if (cmd.too_long)
                    begin
                        st_next = nbrs_pkg::ST_TOO_LONG;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PTR;
                    end
                end
            end
            S_PTR:
            begin
                st_raddr = AW'(addr_reg);
                state_next = S_PTRW;
            end
            S_PTRW:
            begin
                ptr_next = st_rdata;
                idx_next = '0;
                if (st_rdata == nbrs_pkg::END_MARK || {1'b0, st_rdata} <= addr_reg
                    || 32'(st_rdata) >= STORE_BYTES)
                begin
                    if (!c_reg.mode)
                    begin
                        st_next = nbrs_pkg::ST_MISSING;
                        state_next = S_OUT;
                    end
                    else if (32'(addr_reg) + 32'(c_reg.count) + 3 > STORE_BYTES)
                    begin
                        st_next = nbrs_pkg::ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next = nbrs_pkg::ST_ADDED;
                        state_next = S_APP;
                    end
                end
                else if ({1'b0, st_rdata} - addr_reg - 9'd1 == 9'(c_reg.count))
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    addr_next = {1'b0, st_rdata} + 9'd1;
                    state_next = S_PTR;
                end
            end
            S_CMP:
            begin
                if (idx_reg == 9'(c_reg.count))
                begin
                    st_raddr = AW'(ptr_reg);
                    state_next = S_VALW;
                end
                else
                begin
                    st_raddr = AW'(addr_reg + 9'd1 + idx_reg);
                    nb_raddr = NW'(idx_reg);
                    state_next = S_CMPW;
                end
            end
            S_CMPW:
            begin
                if (st_rdata == nb_rdata)
                begin
                    idx_next = idx_reg + 9'd1;
                    state_next = S_CMP;
                end
                else
                begin
                    addr_next = {1'b0, ptr_reg} + 9'd1;
                    state_next = S_PTR;
                end
            end
            S_VALW:
            begin
                // The pointer of a matching record is the address of its value.
                st_next = nbrs_pkg::ST_FOUND;
                if (c_reg.mode)
                begin
                    st_we = 1'b1;
                    st_waddr = AW'(ptr_reg);
                    st_wdata = c_reg.value;
                    state_next = S_OUT;
                end
                else
                begin
                    st_raddr = AW'(ptr_reg);
                    state_next = S_VAL;
                end
            end
            S_VAL:
            begin
                rv_next = st_rdata;
                state_next = S_OUT;
            end
            S_APP:
            begin
                // idx 0 fetches the first name byte; the write trails the read.
                nb_raddr = NW'(idx_reg);
                if (idx_reg == 9'd0)
                begin
                    st_we = 1'b1;
                    st_waddr = AW'(addr_reg);
                    st_wdata = 8'(vaddr);
                end
                state_next = S_APPW;
            end
            S_APPW:
            begin
                if (idx_reg < 9'(c_reg.count))
                begin
                    st_we = 1'b1;
                    st_waddr = AW'(addr_reg + 9'd1 + idx_reg);
                    st_wdata = nb_rdata;
                    idx_next = idx_reg + 9'd1;
                    state_next = S_APP;
                end
                else if (idx_reg == 9'(c_reg.count))
                begin
                    st_we = 1'b1;
                    st_waddr = AW'(vaddr);
                    st_wdata = c_reg.value;
                    idx_next = idx_reg + 9'd1;
                end
                else
                begin
                    st_we = 1'b1;
                    st_waddr = AW'(vaddr + 9'd1);
                    st_wdata = nbrs_pkg::END_MARK;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            init_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        addr_reg <= addr_next;
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        rv_reg <= rv_next;
        st_reg <= st_next;
    end
endmodule
`default_nettype wire

FILE: rtl/core/named_byte_record_store.sv
// A name byte that is not the last is taken with no result; a last byte gives its
// result after the walk of the record list, with a pointer read per record passed, a
// compare per name byte checked and a write per byte written on an append.
// Throughput: one name byte per cycle while in_ready is high; a last byte blocks input
// until the back part has taken its command and the walk and any append end.
// Reset: asynchronous, active low; after reset the end mark is first written at store
// byte 0, and no command is taken before that write.
`default_nettype none
module named_byte_record_store #(
    parameter int STORE_BYTES = 256,
    parameter int MAX_NAME = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       mode,
    input  wire logic [7:0] name_byte,
    input  wire logic       name_end,
    input  wire logic [7:0] value,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_value,
    output logic [2:0]      status
);
    localparam int NW = $clog2(MAX_NAME + 1);

    logic                cmd_valid, cmd_ready, nb_we, back_busy;
    nbrs_pkg::nbrs_cmd_t cmd;
    logic [NW-1:0]       nb_waddr, nb_raddr;
    logic [7:0]          nb_wdata, nb_rdata;

    nbrs_front #(.MAX_NAME(MAX_NAME)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .name_byte(name_byte), .name_end(name_end), .value(value),
        .back_busy(back_busy),
        .nb_we(nb_we), .nb_waddr(nb_waddr), .nb_wdata(nb_wdata),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    nbrs_ram #(.WIDTH(8), .DEPTH(MAX_NAME + 1)) u_name (
        .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
        .raddr(nb_raddr), .rdata(nb_rdata)
    );

    nbrs_back #(.STORE_BYTES(STORE_BYTES), .MAX_NAME(MAX_NAME)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .busy(back_busy), .nb_raddr(nb_raddr), .nb_rdata(nb_rdata),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_value(read_value), .status(status)
    );
endmodule
`default_nettype wire

FILE: rtl/core/nbrs_checker.sv
`default_nettype none
`include "named_byte_record_store_defines.svh"
module nbrs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       name_end,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] read_value,
    input wire logic [2:0] status
);
    `NBRS_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, status <= 3'd4, "bad status")
    `NBRS_ASSERT_IMPL(a_rv_zero, clk, rst_n, out_valid && status != 3'd0,
        read_value == 8'd0, "nonzero read value")
    `NBRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(read_value), "result dropped")
    `NBRS_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && in_ready && !name_end,
        !out_valid || $past(out_valid), "result without last byte")
endmodule

bind named_byte_record_store nbrs_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .name_end(name_end), .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .status(status)
);
`default_nettype wire

FILE: bench/named_byte_record_store_test.sv
`default_nettype none
module named_byte_record_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = 256;
    localparam int MAX_NAME = 32;

    typedef struct packed {
        logic       mode;
        logic [7:0] name_byte;
        logic       name_end;
        logic [7:0] value;
    } name_item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [2:0] status;
    } lookup_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       mode;
    logic [7:0] name_byte;
    logic       name_end;
    logic [7:0] value;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_value;
    logic [2:0] status;

    named_byte_record_store uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .name_byte(name_byte), .name_end(name_end), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_value(read_value), .status(status)
    );

    name_item_t     pending_items[$];
    lookup_result_t expected_results[$];
    int             error_count = 0;
    int             results_seen = 0;
    int             items_sent = 0;
    bit             stimulus_done = 0;
    bit             hold_sender = 0;

    // Predictor state.
    logic [7:0] pred_store[STORE_BYTES];
    logic [7:0] pred_name[MAX_NAME];
    int         pred_count;
    bit         pred_too_long;

    // A random choice of the queued names of legal length, kept so that random reads hit often.
    logic [7:0] known_names[$][$];

    function automatic int store_byte(int a);
        if (a >= STORE_BYTES)
            return 255;
        return pred_store[a];
    endfunction

    // Walks the predicted list; returns the record start or the end of the list.
    function automatic int walk_records(output bit hit);
        int  addr;
        int  p;
        bit  same;
        addr = 0;
        hit = 0;
        forever
        begin
            p = store_byte(addr);
            if (p == nbrs_pkg::END_MARK || p <= addr || p >= STORE_BYTES)
                return addr;
            if (p - addr - 1 == pred_count)
            begin
                same = 1;
                for (int i = 0; i < pred_count; i++)
                    if (store_byte(addr + 1 + i) != pred_name[i])
                        same = 0;
                if (same)
                begin
                    hit = 1;
                    return addr;
                end
            end
            addr = p + 1;
        end
    endfunction

    task automatic predict_item(input name_item_t it);
        lookup_result_t r;
        bit             hit;
        int             addr;
        int             va;
        if (pred_count < MAX_NAME)
        begin
            pred_name[pred_count] = it.name_byte;
            pred_count++;
        end
        else
            pred_too_long = 1;
        if (!it.name_end)
            return;
        r.read_value = 8'd0;
        if (pred_too_long)
            r.status = nbrs_pkg::ST_TOO_LONG;
        else
        begin
            addr = walk_records(hit);
            if (hit)
            begin
                va = store_byte(addr);
                if (it.mode)
                    pred_store[va] = it.value;
                else
                    r.read_value = store_byte(va);
                r.status = nbrs_pkg::ST_FOUND;
            end
            else if (!it.mode)
                r.status = nbrs_pkg::ST_MISSING;
            else if (addr + pred_count + 3 > STORE_BYTES)
                r.status = nbrs_pkg::ST_FULL;
            else
            begin
                va = addr + pred_count + 1;
                pred_store[addr] = va;
                for (int i = 0; i < pred_count; i++)
                    pred_store[addr + 1 + i] = pred_name[i];
                pred_store[va] = it.value;
                pred_store[va + 1] = nbrs_pkg::END_MARK;
                r.status = nbrs_pkg::ST_ADDED;
            end
        end
        pred_count = 0;
        pred_too_long = 0;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Queues one whole name with the operation on its last byte.
    task automatic queue_name(input logic [7:0] nm[$], input logic op, input logic [7:0] v);
        name_item_t it;
        for (int i = 0; i < nm.size(); i++)
        begin
            it.mode = $urandom_range(0, 1);
            it.value = $urandom_range(0, 255);
            it.name_byte = nm[i];
            it.name_end = (i == nm.size() - 1);
            if (it.name_end)
            begin
                it.mode = op;
                it.value = v;
            end
            pending_items.push_back(it);
        end
    endtask

    function automatic void random_name(output logic [7:0] nm[$], input int len);
        nm = {};
        for (int i = 0; i < len; i++)
            nm.push_back($urandom_range(0, 255));
    endfunction

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Driver.
    int send_wait = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            mode      <= 1'b0;
            name_byte <= 8'd0;
            name_end  <= 1'b0;
            value     <= 8'd0;
            send_wait  = $urandom_range(0, 10);
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_item({mode, name_byte, name_end, value});
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0 || hold_sender || pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_wait > 0)
                        send_wait--;
                end
                else
                begin
                    name_item_t it;
                    it = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    mode      <= it.mode;
                    name_byte <= it.name_byte;
                    name_end  <= it.name_end;
                    value     <= it.value;
                    send_wait  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                end
            end
        end
    end

    // Monitor.
    int recv_wait = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                lookup_result_t exp_r;
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (read_value !== exp_r.read_value)
                        report_mismatch($sformatf("read_value %0h, expected %0h",
                                                  read_value, exp_r.read_value));
                    if (status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, exp_r.status));
                end
                recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [7:0] nm[$];
        logic [7:0] full_name[$];
        int         pick;
        rst_n = 1'b0;
        pred_count = 0;
        pred_too_long = 0;
        for (int i = 0; i < STORE_BYTES; i++)
            pred_store[i] = 8'd0;
        pred_store[0] = nbrs_pkg::END_MARK;
        for (int i = 0; i < MAX_NAME; i++)
            pred_name[i] = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: miss on an empty store, add, read back, update, extremes.
        nm = {8'h00};
        queue_name(nm, 1'b0, 8'h00);
        queue_name(nm, 1'b1, 8'hFF);
        queue_name(nm, 1'b0, 8'h00);
        queue_name(nm, 1'b1, 8'h00);
        queue_name(nm, 1'b0, 8'hAA);
        nm = {8'hFF, 8'h55};
        queue_name(nm, 1'b1, 8'h5A);
        queue_name(nm, 1'b0, 8'h00);
        nm = {8'hFF};
        queue_name(nm, 1'b0, 8'h00);
        // A name of the buffer's full length, then one byte too long.
        random_name(full_name, MAX_NAME);
        queue_name(full_name, 1'b1, 8'h81);
        queue_name(full_name, 1'b0, 8'h00);
        random_name(nm, MAX_NAME + 1);
        queue_name(nm, 1'b1, 8'h11);
        queue_name(nm, 1'b0, 8'h00);

        wait (pending_items.size() == 0);
        // Hold the sender until the results have drained completely once.
        hold_sender = 1;
        wait (expected_results.size() == 0 && !in_valid);
        repeat (400) @(posedge clk);
        hold_sender = 0;

        // Random phase: mostly well-formed names, reused often, until 1750 name bytes are queued or sent.
        while (items_sent + pending_items.size() < 1750)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && known_names.size() > 0)
                nm = known_names[$urandom_range(0, known_names.size() - 1)];
            else if (pick < 45)
                random_name(nm, $urandom_range(MAX_NAME + 1, MAX_NAME + 4));
            else if (pick < 50)
                random_name(nm, $urandom_range(MAX_NAME - 2, MAX_NAME));
            else
                random_name(nm, $urandom_range(1, 6));
            if (nm.size() <= MAX_NAME && $urandom_range(0, 1))
                known_names.push_back(nm);
            queue_name(nm, $urandom_range(0, 1), $urandom_range(0, 255));
            wait (pending_items.size() < 8);
        end
        wait (pending_items.size() == 0);
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        wait (expected_results.size() == 0 && !in_valid);
        repeat (400) @(posedge clk);
        $display("Sent %0d name bytes and checked %0d lookup results,", items_sent, results_seen);
        $display("covering reads, updates, appends, a full store and over-long names.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
